>>> rtl/core/u2a_pkg.sv
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types, constants and decode functions for the UTF-8 to ASCII
// transliterator: job format between front and back, lead byte classing
// and the code point to printable character map.
// ----------------------------------------------------------------------------
package u2a_pkg;

   localparam logic [7:0] MaxCharsReset = 8'd201;
   localparam logic [7:0] CharUnknown   = "?";

   // One decode job: up to four bytes, how many are present, how many
   // characters may still be emitted, and whether the string ends here.
   typedef struct packed {
      logic [31:0] bytes;
      logic [2:0]  count;
      logic [1:0]  limit;
      logic        last;
   } job_type;

   // Continuation bytes that a lead byte calls for (0 for ASCII or invalid)
   function automatic logic [1:0] cont_need(input logic [7:0] b);
      logic [1:0] need;
      need = 2'd0;
      if (b[7] == 1'b0) begin
         need = 2'd0;
      end else if ((b & 8'hE0) == 8'hC0) begin
         need = 2'd1;
      end else if ((b & 8'hF0) == 8'hE0) begin
         need = 2'd2;
      end else if ((b & 8'hF8) == 8'hF0) begin
         need = 2'd3;
      end
      return need;
   endfunction

   // Code point to printable ASCII
   function automatic logic [7:0] to_ascii(input logic [20:0] cp);
      logic [7:0] c;
      logic [7:0] lo;
      lo = cp[7:0];
      c  = CharUnknown;
      if (cp >= 21'h20 && cp <= 21'h7E) begin
         c = lo;
      end else if (cp == 21'h2D9) begin
         c = "o";
      end else if (cp > 21'hFF) begin
         c = CharUnknown;
      end else if (lo >= 8'hC0 && lo <= 8'hC6) begin
         c = "A";
      end else if (lo >= 8'hE0 && lo <= 8'hE6) begin
         c = "a";
      end else if (lo >= 8'hE8 && lo <= 8'hEB) begin
         c = "e";
      end else if (lo >= 8'hEC && lo <= 8'hEF) begin
         c = "i";
      end else if (lo >= 8'hF2 && lo <= 8'hF6) begin
         c = "o";
      end else if (lo >= 8'hF9 && lo <= 8'hFC) begin
         c = "u";
      end else if (lo >= 8'hD3 && lo <= 8'hD6) begin
         c = "O";
      end else if (lo >= 8'hC9 && lo <= 8'hCB) begin
         c = "E";
      end else begin
         case (lo)
            8'hC7:        c = "C";
            8'hCE, 8'hCF: c = "I";
            8'hD0:        c = "D";
            8'hD1:        c = "N";
            8'hD2:        c = "n";
            8'hD8:        c = "O";
            8'hD9:        c = "o";
            8'hDA, 8'hDC: c = "U";
            8'hDD:        c = "Y";
            8'hDE:        c = "T";
            8'hDF:        c = "s";
            8'hE7:        c = "c";
            8'hF0:        c = "d";
            8'hF1:        c = "n";
            8'hF8:        c = "o";
            8'hFD, 8'hFF: c = "y";
            8'hB7:        c = "a";
            8'hC8:        c = "e";
            8'hCD:        c = "e";
            8'hDB:        c = "o";
            8'hCC:        c = "i";
            8'hAF:        c = "o";
            8'hAC:        c = "A";
            default:      c = CharUnknown;
         endcase
      end
      return c;
   endfunction

endpackage

>>> rtl/core/u2a_front.sv
// ----------------------------------------------------------------------------
// u2a_front
// Accepts input bytes, collects multi-byte sequences, counts characters
// against the limit and hands complete sequences or end flushes to the queue.
// ----------------------------------------------------------------------------
module u2a_front
   import u2a_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_max_chars,
   input  logic        queue_full,
   output logic        push_valid,
   output job_type     push_job
);

   logic [7:0]  max_chars_ff;
   logic [23:0] held_ff, held_in;
   logic [1:0]  held_cnt_ff, held_cnt_in;
   logic [7:0]  emitted_ff, emitted_in;

   logic        accept;
   logic        room;
   logic [31:0] buf_vec;
   logic [2:0]  avail;
   logic [1:0]  need;
   logic [7:0]  budget;
   logic [1:0]  flush_limit;

   assign req_stall = queue_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !queue_full;

   // sequence assembly and job generation
   always_comb begin
      room    = (emitted_ff < max_chars_ff);
      buf_vec = {8'h00, held_ff};
      if (room) begin
         buf_vec[{held_cnt_ff, 3'b000} +: 8] = req_in_byte;
      end
      avail  = {1'b0, held_cnt_ff} + {2'b00, room};
      need   = cont_need(buf_vec[7:0]);
      budget = max_chars_ff - emitted_ff;
      if (!room) begin
         flush_limit = 2'd0;
      end else if (budget >= 8'd3) begin
         flush_limit = 2'd3;
      end else begin
         flush_limit = budget[1:0];
      end

      held_in        = held_ff;
      held_cnt_in    = held_cnt_ff;
      emitted_in     = emitted_ff;
      push_valid     = 1'b0;
      push_job.bytes = buf_vec;
      push_job.count = avail;
      push_job.limit = flush_limit;
      push_job.last  = req_last_byte;

      if (accept) begin
         if (req_last_byte) begin
            // end of string: flush whatever is held
            push_valid  = 1'b1;
            held_cnt_in = 2'd0;
            emitted_in  = 8'd0;
         end else if (avail != 3'd0) begin
            if (room && avail >= ({1'b0, need} + 3'd1)) begin
               push_valid     = 1'b1;
               push_job.limit = 2'd1;
               held_cnt_in    = 2'd0;
               emitted_in     = emitted_ff + 8'd1;
            end else begin
               held_in     = buf_vec[23:0];
               held_cnt_in = (avail > 3'd3) ? 2'd3 : avail[1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= MaxCharsReset;
         held_cnt_ff  <= 2'd0;
         emitted_ff   <= 8'd0;
      end else begin
         if (csr_valid) begin
            max_chars_ff <= csr_max_chars;
         end
         held_cnt_ff <= held_cnt_in;
         emitted_ff  <= emitted_in;
      end
      held_ff <= held_in;
   end

endmodule

>>> rtl/core/u2a_queue.sv
// ----------------------------------------------------------------------------
// u2a_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module u2a_queue
   import u2a_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PtrLast = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CntFull = CNT_W'(DEPTH);

   job_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full       = (cnt_ff == CntFull);
   assign head_valid = (cnt_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/core/u2a_back.sv
// ----------------------------------------------------------------------------
// u2a_back
// Decodes queued jobs into ASCII characters, one result beat per cycle when
// not stalled, and holds each beat in the output register until it is taken.
// ----------------------------------------------------------------------------
module u2a_back
   import u2a_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_end_of_string
);

   logic [2:0]  pos_ff, pos_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        valid_ff, valid_in;
   logic [6:0]  char_ff, char_in;
   logic        cvalid_ff, cvalid_in;
   logic        eos_ff, eos_in;

   logic        can_load, fire;
   logic [31:0] window;
   logic [2:0]  avail;
   logic [7:0]  lead;
   logic [1:0]  need;
   logic        full_seq;
   logic [20:0] cp;
   logic [2:0]  used;
   logic        bare;
   logic        done;
   logic [7:0]  ascii;

   assign can_load = !valid_ff || !rsp_stall;
   assign fire     = head_valid && can_load;

   // decode one code point at the current position
   always_comb begin
      window   = head_job.bytes >> {pos_ff, 3'b000};
      avail    = head_job.count - pos_ff;
      lead     = window[7:0];
      need     = cont_need(lead);
      full_seq = (need != 2'd0) && (({1'b0, need} + 3'd1) <= avail);
      cp       = {13'd0, CharUnknown};
      used     = 3'd1;
      if (lead[7] == 1'b0) begin
         cp = {13'd0, lead};
      end else if (full_seq) begin
         used = {1'b0, need} + 3'd1;
         case (need)
            2'd1:    cp = {10'd0, lead[4:0], window[13:8]};
            2'd2:    cp = {5'd0, lead[3:0], window[13:8], window[21:16]};
            default: cp = {lead[2:0], window[13:8], window[21:16], window[29:24]};
         endcase
      end
      ascii = to_ascii(cp);
      bare  = (head_job.count == 3'd0) || (head_job.limit == 2'd0);
      done  = bare || ((pos_ff + used) >= head_job.count)
            || (({1'b0, cnt_ff} + 3'd1) == {1'b0, head_job.limit});
   end

   // result beat and position update
   always_comb begin
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      valid_in  = valid_ff && rsp_stall;
      char_in   = char_ff;
      cvalid_in = cvalid_ff;
      eos_in    = eos_ff;
      pop       = 1'b0;
      if (fire) begin
         valid_in  = 1'b1;
         char_in   = bare ? 7'd0 : ascii[6:0];
         cvalid_in = !bare;
         eos_in    = head_job.last && done;
         if (done) begin
            pop    = 1'b1;
            pos_in = 3'd0;
            cnt_in = 2'd0;
         end else begin
            pos_in = pos_ff + used;
            cnt_in = cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 3'd0;
         cnt_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
      char_ff   <= char_in;
      cvalid_ff <= cvalid_in;
      eos_ff    <= eos_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_char      = char_ff;
   assign rsp_char_valid    = cvalid_ff;
   assign rsp_end_of_string = eos_ff;

endmodule

>>> rtl/core/utf8_to_ascii_transliterator_core.sv
// ----------------------------------------------------------------------------
// utf8_to_ascii_transliterator_core
// Streams a UTF-8 string byte by byte and emits one printable ASCII
// character per decoded code point, limited to max_chars per string.
//
//   channel  direction  handshake          beat
//   req_     in         req_valid/stall    in_byte, last_byte
//   rsp_     out        rsp_valid/stall    out_char, char_valid, end_of_string
//   csr_     in         csr_valid/ready    max_chars
//
// One input beat per cycle is taken while the job queue has room.
// The back-end decoder emits result beats one at a time; an end-of-string
// flush emits up to three beats and holds the queue head until they are out.
// A job is registered in the job queue, then its result in the output register.
// Reset is synchronous, discards held bytes and clears counters and the queue;
// max_chars returns to 201. Output stall backs up through the queue.
// ----------------------------------------------------------------------------
module utf8_to_ascii_transliterator_core
   import u2a_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_end_of_string,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_max_chars
);

   logic    push_valid;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   u2a_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_max_chars (csr_max_chars),
      .queue_full    (queue_full),
      .push_valid    (push_valid),
      .push_job      (push_job)
   );

   u2a_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   u2a_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_job          (head_job),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_char      (rsp_out_char),
      .rsp_char_valid    (rsp_char_valid),
      .rsp_end_of_string (rsp_end_of_string)
   );

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_to_ascii_transliterator_core. Strings are fed
// one byte per beat. A short directed table covers the corner cases, then
// random strings follow under several character limits. Mostly they are
// well-formed UTF-8, with some invalid leads, broken sequences and cut-off
// tails mixed in. A local transliteration model predicts the beats of every
// untyped row; a scoreboard checks each beat in order while the result side
// stalls at random.
// ----------------------------------------------------------------------------
module tb
   import u2a_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400_000;
   localparam int DRAIN_CYCLES = 16;
   localparam int NUM_PHASES   = 7;

   typedef enum logic {RowByte, RowCsr} row_kind_type;
   typedef enum logic [1:0] {StallNone, StallLight, StallHalf, StallHeavy} stall_mode_type;

   // One result beat
   typedef struct packed {
      logic [6:0] ch;
      logic       valid;
      logic       eos;
   } glyph_type;

   // One directed step; typed rows carry their expected characters,
   // packed with the first character in the highest used byte
   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   data;
      logic         last;
      logic         typed;
      logic [1:0]   n_chars;
      logic [23:0]  chars;
   } stim_row_type;

   logic       clock;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte       = 8'h00;
   logic       req_last_byte     = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall         = 1'b0;
   logic [6:0] rsp_out_char;
   logic       rsp_char_valid;
   logic       rsp_end_of_string;
   logic       csr_valid         = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_max_chars     = 8'h00;

   // Predictor state
   logic [7:0]  char_limit  = MaxCharsReset;
   logic [23:0] pending_seq = 24'd0;
   int          pending_len = 0;
   int          chars_out   = 0;

   glyph_type   fresh_glyphs[$];
   glyph_type   due_glyphs[$];
   logic [7:0]  string_q[$];

   int          errors      = 0;
   int          cycle_count = 0;
   int          burst_left  = 0;
   int          bytes_taken = 0;

   stall_mode_type stall_mode = StallNone;
   int             stall_run  = 0;

   stim_row_type directed_rows [30] = '{
      '{RowByte, 8'h41, 1'b1, 1'b1, 2'd1, 24'("A")},    // plain ASCII after reset
      '{RowByte, 8'h7E, 1'b0, 1'b1, 2'd1, 24'("~")},    // top printable
      '{RowByte, 8'h20, 1'b1, 1'b1, 2'd1, 24'(" ")},    // bottom printable
      '{RowByte, 8'h01, 1'b1, 1'b1, 2'd1, 24'("?")},    // control char
      '{RowByte, 8'hFF, 1'b1, 1'b1, 2'd1, 24'("?")},    // invalid lead
      '{RowByte, 8'hC3, 1'b0, 1'b0, 2'd0, 24'd0},       // two-byte Latin-1
      '{RowByte, 8'hA9, 1'b1, 1'b0, 2'd0, 24'd0},
      '{RowByte, 8'hE2, 1'b0, 1'b0, 2'd0, 24'd0},       // three-byte
      '{RowByte, 8'h82, 1'b0, 1'b0, 2'd0, 24'd0},
      '{RowByte, 8'hAC, 1'b1, 1'b0, 2'd0, 24'd0},
      '{RowByte, 8'hF0, 1'b0, 1'b0, 2'd0, 24'd0},       // four-byte
      '{RowByte, 8'h9F, 1'b0, 1'b0, 2'd0, 24'd0},
      '{RowByte, 8'h98, 1'b0, 1'b0, 2'd0, 24'd0},
      '{RowByte, 8'h80, 1'b1, 1'b0, 2'd0, 24'd0},
      '{RowByte, 8'hCB, 1'b0, 1'b0, 2'd0, 24'd0},       // mojibake dot above
      '{RowByte, 8'h99, 1'b1, 1'b0, 2'd0, 24'd0},
      '{RowByte, 8'hC3, 1'b0, 1'b0, 2'd0, 24'd0},       // ASCII as continuation
      '{RowByte, 8'h41, 1'b1, 1'b0, 2'd0, 24'd0},
      '{RowByte, 8'hF0, 1'b0, 1'b0, 2'd0, 24'd0},       // string ends mid-sequence
      '{RowByte, 8'h41, 1'b0, 1'b0, 2'd0, 24'd0},
      '{RowByte, 8'h42, 1'b1, 1'b1, 2'd3, 24'("?AB")},
      '{RowCsr,  8'd0,  1'b0, 1'b0, 2'd0, 24'd0},       // limit zero: bare end
      '{RowByte, 8'h78, 1'b1, 1'b1, 2'd0, 24'd0},
      '{RowCsr,  8'd1,  1'b0, 1'b0, 2'd0, 24'd0},       // limit reached
      '{RowByte, 8'h61, 1'b0, 1'b1, 2'd1, 24'("a")},
      '{RowByte, 8'h62, 1'b1, 1'b1, 2'd0, 24'd0},
      '{RowCsr,  8'd255, 1'b0, 1'b0, 2'd0, 24'd0},      // limit lowered mid-sequence
      '{RowByte, 8'hC3, 1'b0, 1'b0, 2'd0, 24'd0},
      '{RowCsr,  8'd0,  1'b0, 1'b0, 2'd0, 24'd0},
      '{RowByte, 8'hA9, 1'b1, 1'b1, 2'd0, 24'd0}
   };

   utf8_to_ascii_transliterator_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_char      (rsp_out_char),
      .rsp_char_valid    (rsp_char_valid),
      .rsp_end_of_string (rsp_end_of_string),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_max_chars     (csr_max_chars)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result-side stall: modes from none to heavy, each held for a random run
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_run  <= $urandom_range(16, 80);
      end else begin
         stall_run <= stall_run - 1;
      end
      case (stall_mode)
         StallNone:  rsp_stall <= 1'b0;
         StallLight: rsp_stall <= ($urandom_range(0, 3) == 0);
         StallHalf:  rsp_stall <= ($urandom_range(0, 1) == 0);
         default:    rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Scoreboard: every accepted result beat against the oldest expectation
   always @(posedge clock) begin
      glyph_type got;
      glyph_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_out_char, rsp_char_valid, rsp_end_of_string};
         if (due_glyphs.size() == 0) begin
            $display("%0t: unexpected beat char %h valid %b end %b",
                     $time, got.ch, got.valid, got.eos);
            errors++;
         end else begin
            want = due_glyphs.pop_front();
            if (got.ch !== want.ch) begin
               $display("%0t: out_char expected %h actual %h", $time, want.ch, got.ch);
               errors++;
            end
            if (got.valid !== want.valid) begin
               $display("%0t: char_valid expected %b actual %b",
                        $time, want.valid, got.valid);
               errors++;
            end
            if (got.eos !== want.eos) begin
               $display("%0t: end_of_string expected %b actual %b",
                        $time, want.eos, got.eos);
               errors++;
            end
         end
      end
   end

   // Continuation bytes a lead byte asks for
   function automatic int cont_count(input logic [7:0] b);
      case (b) inside
         8'b0???????: return 0;
         8'b110?????: return 1;
         8'b1110????: return 2;
         8'b11110???: return 3;
         default:     return 0;
      endcase
   endfunction

   // Code point at byte pos of an n-byte run; a lead short of bytes gives '?'
   function automatic logic [20:0] code_point_at(input logic [31:0] run, input int pos,
                                                 input int n, output int used);
      logic [7:0] lead;
      int         extra;
      lead  = run[8*pos +: 8];
      extra = cont_count(lead);
      used  = 1;
      if (!lead[7]) return {13'd0, lead};
      if (extra == 0 || pos + extra >= n) return 21'h3F;
      used = extra + 1;
      case (extra)
         1:       return {10'd0, lead[4:0], run[8*pos+8 +: 6]};
         2:       return {5'd0, lead[3:0], run[8*pos+8 +: 6], run[8*pos+16 +: 6]};
         default: return {lead[2:0], run[8*pos+8 +: 6], run[8*pos+16 +: 6],
                          run[8*pos+24 +: 6]};
      endcase
   endfunction

   // Printable ASCII for a code point
   function automatic logic [7:0] ascii_of(input logic [20:0] cp);
      logic [7:0] lo;
      lo = cp[7:0];
      if (cp >= 21'h20 && cp <= 21'h7E) return lo;
      if (cp == 21'h2D9) return "o";
      if (cp > 21'hFF) return "?";
      if (lo >= 8'hC0 && lo <= 8'hC6 || lo == 8'hAC) return "A";
      if (lo >= 8'hE0 && lo <= 8'hE6 || lo == 8'hB7) return "a";
      if (lo >= 8'hE8 && lo <= 8'hEB || lo == 8'hC8 || lo == 8'hCD) return "e";
      if (lo >= 8'hEC && lo <= 8'hEF || lo == 8'hCC) return "i";
      if (lo >= 8'hF2 && lo <= 8'hF6 || lo == 8'hF8 || lo == 8'hD9 ||
          lo == 8'hDB || lo == 8'hAF) return "o";
      if (lo >= 8'hF9 && lo <= 8'hFC) return "u";
      if (lo >= 8'hD3 && lo <= 8'hD6 || lo == 8'hD8) return "O";
      if (lo >= 8'hC9 && lo <= 8'hCB) return "E";
      case (lo) inside
         8'hC7:        return "C";
         8'hCE, 8'hCF: return "I";
         8'hD0:        return "D";
         8'hD1:        return "N";
         8'hD2, 8'hF1: return "n";
         8'hDA, 8'hDC: return "U";
         8'hDD:        return "Y";
         8'hDE:        return "T";
         8'hDF:        return "s";
         8'hE7:        return "c";
         8'hF0:        return "d";
         8'hFD, 8'hFF: return "y";
         default:      return "?";
      endcase
   endfunction

   // Predict the beats one input byte causes; fills fresh_glyphs
   task automatic transliterate(input logic [7:0] b, input logic last);
      logic [31:0] run;
      logic [20:0] cp;
      logic [7:0]  c;
      glyph_type   g;
      int          n;
      int          pos;
      int          used;
      fresh_glyphs.delete();
      run = {8'd0, pending_seq};
      n   = pending_len;
      if (chars_out < char_limit) begin
         run[8*n +: 8] = b;
         n++;
      end
      // mid-string: emit once the sequence is whole, else keep holding
      if (!last) begin
         if (n == 0) return;
         if (n > cont_count(run[7:0]) && chars_out < char_limit) begin
            cp = code_point_at(run, 0, n, used);
            c  = ascii_of(cp);
            fresh_glyphs.push_back('{c[6:0], 1'b1, 1'b0});
            chars_out++;
            pending_len = 0;
         end else begin
            pending_seq = run[23:0];
            pending_len = (n > 3) ? 3 : n;
         end
         return;
      end
      // end of string: flush held bytes, at most three characters
      pos = 0;
      while (pos < n && chars_out < char_limit && fresh_glyphs.size() < 3) begin
         cp = code_point_at(run, pos, n, used);
         c  = ascii_of(cp);
         fresh_glyphs.push_back('{c[6:0], 1'b1, 1'b0});
         chars_out++;
         pos += used;
      end
      if (fresh_glyphs.size() == 0) fresh_glyphs.push_back('{7'd0, 1'b0, 1'b0});
      g     = fresh_glyphs.pop_back();
      g.eos = 1'b1;
      fresh_glyphs.push_back(g);
      pending_seq = 24'd0;
      pending_len = 0;
      chars_out   = 0;
   endtask

   // Drive one byte beat in bursts with random gaps, then book its results
   task automatic send_byte(input stim_row_type row);
      glyph_type g;
      int        k;
      int        nch;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      bytes_taken++;
      req_valid     <= 1'b1;
      req_in_byte   <= row.data;
      req_last_byte <= row.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      transliterate(row.data, row.last);
      if (!row.typed) begin
         for (k = 0; k < fresh_glyphs.size(); k++) due_glyphs.push_back(fresh_glyphs[k]);
      end else begin
         nch = row.n_chars;
         for (k = 0; k < nch; k++) begin
            g.ch    = row.chars[8*(nch-1-k) +: 7];
            g.valid = 1'b1;
            g.eos   = row.last && (k == nch - 1);
            due_glyphs.push_back(g);
         end
         if (row.last && nch == 0) due_glyphs.push_back('{7'd0, 1'b0, 1'b1});
      end
   endtask

   // Hold the sender until every expected beat is out and the core settles
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (due_glyphs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_char_limit(input logic [7:0] v);
      wait_idle();
      csr_valid     <= 1'b1;
      csr_max_chars <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      char_limit  = v;
   endtask

   function automatic logic [7:0] random_lead(input int extra);
      case (extra)
         1:       return {3'b110, 5'($urandom_range(0, 31))};
         2:       return {4'b1110, 4'($urandom_range(0, 15))};
         default: return {5'b11110, 3'($urandom_range(0, 7))};
      endcase
   endfunction

   task automatic put_utf8(input logic [20:0] cp);
      if (cp < 21'h80) begin
         string_q.push_back(cp[7:0]);
      end else if (cp < 21'h800) begin
         string_q.push_back({3'b110, cp[10:6]});
         string_q.push_back({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         string_q.push_back({4'b1110, cp[15:12]});
         string_q.push_back({2'b10, cp[11:6]});
         string_q.push_back({2'b10, cp[5:0]});
      end else begin
         string_q.push_back({5'b11110, cp[20:18]});
         string_q.push_back({2'b10, cp[17:12]});
         string_q.push_back({2'b10, cp[11:6]});
         string_q.push_back({2'b10, cp[5:0]});
      end
   endtask

   // Random string: mostly well-formed, some invalid leads and broken bits
   task automatic build_string();
      int units;
      int u;
      int roll;
      int extra;
      int j;
      string_q.delete();
      units = $urandom_range(1, 10);
      for (u = 0; u < units; u++) begin
         roll = $urandom_range(0, 99);
         if (roll < 30) begin
            string_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
         end else if (roll < 34) begin
            string_q.push_back(($urandom_range(0, 7) == 0) ? 8'h7F
                                                           : 8'($urandom_range(1, 31)));
         end else if (roll < 58) begin
            put_utf8(($urandom_range(0, 15) == 0) ? 21'h2D9
                                                  : 21'($urandom_range(8'hA0, 8'hFF)));
         end else if (roll < 64) begin
            put_utf8(21'($urandom_range(21'h80, 21'h7FF)));
         end else if (roll < 74) begin
            put_utf8(21'($urandom_range(21'h800, 21'hFFFF)));
         end else if (roll < 80) begin
            put_utf8(21'($urandom_range(21'h10000, 21'h10FFFF)));
         end else if (roll < 88) begin
            string_q.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                                         : 8'($urandom_range(8'hF8, 8'hFF)));
         end else begin
            // lead followed by too few bytes of any nonzero value
            extra = $urandom_range(1, 3);
            string_q.push_back(random_lead(extra));
            for (j = $urandom_range(0, extra - 1); j > 0; j--)
               string_q.push_back(8'($urandom_range(1, 255)));
         end
      end
      // cut-off sequence at the tail
      if ($urandom_range(0, 5) == 0) begin
         extra = $urandom_range(1, 3);
         string_q.push_back(random_lead(extra));
         for (j = $urandom_range(0, extra - 1); j > 0; j--)
            string_q.push_back({2'b10, 6'($urandom_range(0, 63))});
      end
   endtask

   // Main sequence
   initial begin
      logic [7:0] fixed_limits [5];
      logic [7:0] lim;
      int         r;
      int         ph;
      int         k;
      int         budget;
      fixed_limits = '{8'd255, 8'd3, 8'd1, 8'd0, MaxCharsReset};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (r = 0; r < $size(directed_rows); r++) begin
         if (directed_rows[r].kind == RowCsr) begin
            set_char_limit(directed_rows[r].data);
         end else begin
            send_byte(directed_rows[r]);
         end
      end

      // random strings, one limit per phase
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         lim = (ph < 5) ? fixed_limits[ph] : 8'($urandom_range(2, 255));
         set_char_limit(lim);
         bytes_taken = 0;
         budget      = (lim == 8'd0) ? 15 : 75;
         while (bytes_taken < budget) begin
            build_string();
            for (k = 0; k < string_q.size(); k++)
               send_byte('{RowByte, string_q[k], k == string_q.size() - 1,
                           1'b0, 2'd0, 24'd0});
         end
      end

      wait_idle();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> utf8_to_ascii_transliterator_core.f
rtl/core/u2a_pkg.sv
rtl/core/u2a_front.sv
rtl/core/u2a_queue.sv
rtl/core/u2a_back.sv
rtl/core/utf8_to_ascii_transliterator_core.sv
tb/tb.sv
